/* rtl/modbus_rtu_register_poller_core_defines.svh */
// ----------------------------------------------------------------------------
// Modbus RTU register poller: assertion macros
// Macros for concurrent checks. They are empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef MODBUS_RTU_REGISTER_POLLER_CORE_DEFINES_SVH
`define MODBUS_RTU_REGISTER_POLLER_CORE_DEFINES_SVH

`ifndef SYNTH
`define MBRTU_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("modbus poller check failed");
`define MBRTU_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("modbus poller check failed");
`else
`define MBRTU_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define MBRTU_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif

`endif

/* rtl/mbrtu_pkg.sv */
// ----------------------------------------------------------------------------
// Modbus RTU register poller: package
// Beat types, register indexes, frame constants and the CRC-16 byte step.
// ----------------------------------------------------------------------------
package mbrtu_pkg;

  localparam int TIMER_BITS = 16;
  localparam int CMP_W      = (TIMER_BITS > 16) ? TIMER_BITS : 16;

  localparam logic [15:0] CRC_INIT  = 16'hFFFF;
  localparam logic [15:0] CRC_POLY  = 16'hA001;
  localparam logic [7:0]  REQ_COUNT = 8'h02;
  localparam logic [7:0]  REQ_ZERO  = 8'h00;

  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_BYTE = 1'b1;

  localparam logic [2:0] REG_POLL_PERIOD  = 3'd0;
  localparam logic [2:0] REG_TIMEOUT      = 3'd1;
  localparam logic [2:0] REG_MAX_FAILURES = 3'd2;
  localparam logic [2:0] REG_SLAVE_ADDR   = 3'd3;
  localparam logic [2:0] REG_FUNC_CODE    = 3'd4;

  localparam logic [2:0] FRM_ADDR    = 3'd0;
  localparam logic [2:0] FRM_FUNC    = 3'd1;
  localparam logic [2:0] FRM_START_H = 3'd2;
  localparam logic [2:0] FRM_START_L = 3'd3;
  localparam logic [2:0] FRM_COUNT_H = 3'd4;
  localparam logic [2:0] FRM_COUNT_L = 3'd5;
  localparam logic [2:0] FRM_CRC_L   = 3'd6;
  localparam logic [2:0] FRM_CRC_H   = 3'd7;

  localparam logic [3:0] RX_CRC_LO_POS = 4'd7;

  typedef struct packed {
    logic       cmd;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic               tx_valid;
    logic [7:0]         tx_byte;
    logic signed [15:0] joy_x;
    logic signed [15:0] joy_y;
    logic               link_active;
    logic [7:0]         failure_count;
    logic               last;
  } result_t;

  function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

/* rtl/modbus_rtu_register_poller_core.sv */
// ----------------------------------------------------------------------------
// Modbus RTU register poller core
// Polls one slave for two holding registers and reports the values and link.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                   payload
//  item      in         item_valid / item_stall     mbrtu_pkg::item_t
//  result    out        result_valid / result_stall mbrtu_pkg::result_t
//  cfg       in         cfg_we                      cfg_index, cfg_data
//
// An item is processed in the cycle it is accepted and its first result beat
// is registered at that edge. A tick that sends streams eight beats, one per
// cycle unless stalled, from the result register; the request CRC is built
// byte by byte as the frame goes out. Every other item gives one beat, and a
// new item is taken in the cycle its predecessor's last beat leaves. Stalls on
// the result side hold the beat and push back on the item side. Reset is
// synchronous and restores all but the result payload register to defaults.
// ----------------------------------------------------------------------------
`include "modbus_rtu_register_poller_core_defines.svh"

module modbus_rtu_register_poller_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  mbrtu_pkg::item_t    item,
  output logic                result_valid,
  input  logic                result_stall,
  output mbrtu_pkg::result_t  result,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_data
);

  localparam logic [mbrtu_pkg::TIMER_BITS-1:0] TMAX = '1;

  logic [15:0] poll_period;
  logic [15:0] timeout;
  logic [7:0]  max_failures;
  logic [7:0]  slave_address;
  logic [7:0]  function_code;

  logic                            waiting_reply, waiting_reply_next;
  logic [mbrtu_pkg::TIMER_BITS-1:0] elapsed_ticks, elapsed_ticks_next;
  logic [3:0]                      rx_count, rx_count_next;
  logic [15:0]                     rx_crc, rx_crc_next;
  logic                            header_ok, header_ok_next;
  logic [31:0]                     data_bytes, data_bytes_next;
  logic [7:0]                      crc_low_byte, crc_low_byte_next;
  logic [15:0]                     x_value, x_value_next;
  logic [15:0]                     y_value, y_value_next;
  logic [7:0]                      failures, failures_next;
  logic                            link_up, link_up_next;

  logic        bursting;
  logic [2:0]  tx_idx;
  logic [15:0] tx_crc;
  logic [7:0]  tx_byte_sel;

  logic                            item_fire;
  logic                            result_fire;
  logic                            send;
  logic [mbrtu_pkg::TIMER_BITS-1:0] elapsed_inc;
  logic [7:0]                      failures_inc;

  assign item_fire   = item_valid && !item_stall;
  assign result_fire = result_valid && !result_stall;
  assign item_stall  = result_valid && !(!result_stall && result.last);

  assign elapsed_inc  = (elapsed_ticks != TMAX) ? elapsed_ticks + 1'b1 : elapsed_ticks;
  assign failures_inc = (failures != 8'hFF) ? failures + 8'd1 : failures;

  assign send = item_fire && (item.cmd == mbrtu_pkg::CMD_TICK) && !waiting_reply &&
                (mbrtu_pkg::CMP_W'(elapsed_inc) >= mbrtu_pkg::CMP_W'(poll_period));

  always_comb begin
    waiting_reply_next = waiting_reply;
    elapsed_ticks_next = elapsed_ticks;
    rx_count_next      = rx_count;
    rx_crc_next        = rx_crc;
    header_ok_next     = header_ok;
    data_bytes_next    = data_bytes;
    crc_low_byte_next  = crc_low_byte;
    x_value_next       = x_value;
    y_value_next       = y_value;
    failures_next      = failures;
    link_up_next       = link_up;
    if (item_fire) begin
      if (item.cmd == mbrtu_pkg::CMD_TICK) begin
        elapsed_ticks_next = elapsed_inc;
        if (!waiting_reply) begin
          if (send) begin
            elapsed_ticks_next = '0;
            waiting_reply_next = 1'b1;
            rx_count_next      = '0;
            rx_crc_next        = mbrtu_pkg::CRC_INIT;
            header_ok_next     = 1'b1;
            data_bytes_next    = '0;
            crc_low_byte_next  = '0;
          end
        end else if (mbrtu_pkg::CMP_W'(elapsed_inc) >= mbrtu_pkg::CMP_W'(timeout)) begin
          failures_next = failures_inc;
          if (failures_inc >= max_failures) begin
            x_value_next = '0;
            y_value_next = '0;
            link_up_next = 1'b0;
          end
          waiting_reply_next = 1'b0;
          rx_count_next      = '0;
          rx_crc_next        = mbrtu_pkg::CRC_INIT;
          header_ok_next     = 1'b1;
          data_bytes_next    = '0;
          crc_low_byte_next  = '0;
        end
      end else if (waiting_reply) begin
        if (rx_count < mbrtu_pkg::RX_CRC_LO_POS) begin
          rx_crc_next = mbrtu_pkg::crc_feed(rx_crc, item.rx_byte);
          if (rx_count == 4'd0 && item.rx_byte != slave_address) begin
            header_ok_next = 1'b0;
          end
          if (rx_count == 4'd1 && item.rx_byte != function_code) begin
            header_ok_next = 1'b0;
          end
          if (rx_count >= 4'd3) begin
            data_bytes_next = {data_bytes[23:0], item.rx_byte};
          end
          rx_count_next = rx_count + 4'd1;
        end else if (rx_count == mbrtu_pkg::RX_CRC_LO_POS) begin
          crc_low_byte_next = item.rx_byte;
          rx_count_next     = rx_count + 4'd1;
        end else begin
          if ({item.rx_byte, crc_low_byte} == rx_crc && header_ok) begin
            failures_next = '0;
            link_up_next  = 1'b1;
            x_value_next  = data_bytes[31:16];
            y_value_next  = data_bytes[15:0];
          end else begin
            failures_next = failures_inc;
          end
          waiting_reply_next = 1'b0;
          rx_count_next      = '0;
          rx_crc_next        = mbrtu_pkg::CRC_INIT;
          header_ok_next     = 1'b1;
          data_bytes_next    = '0;
          crc_low_byte_next  = '0;
        end
      end
    end
  end

  always_comb begin
    case (tx_idx)
      mbrtu_pkg::FRM_ADDR:    tx_byte_sel = slave_address;
      mbrtu_pkg::FRM_FUNC:    tx_byte_sel = function_code;
      mbrtu_pkg::FRM_START_H: tx_byte_sel = mbrtu_pkg::REQ_ZERO;
      mbrtu_pkg::FRM_START_L: tx_byte_sel = mbrtu_pkg::REQ_ZERO;
      mbrtu_pkg::FRM_COUNT_H: tx_byte_sel = mbrtu_pkg::REQ_ZERO;
      mbrtu_pkg::FRM_COUNT_L: tx_byte_sel = mbrtu_pkg::REQ_COUNT;
      mbrtu_pkg::FRM_CRC_L:   tx_byte_sel = tx_crc[7:0];
      mbrtu_pkg::FRM_CRC_H:   tx_byte_sel = tx_crc[15:8];
      default:                tx_byte_sel = mbrtu_pkg::REQ_ZERO;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      poll_period   <= 16'd20;
      timeout       <= 16'd50;
      max_failures  <= 8'd3;
      slave_address <= 8'd3;
      function_code <= 8'd3;
    end else if (cfg_we) begin
      case (cfg_index)
        mbrtu_pkg::REG_POLL_PERIOD:  poll_period   <= cfg_data;
        mbrtu_pkg::REG_TIMEOUT:      timeout       <= cfg_data;
        mbrtu_pkg::REG_MAX_FAILURES: max_failures  <= cfg_data[7:0];
        mbrtu_pkg::REG_SLAVE_ADDR:   slave_address <= cfg_data[7:0];
        mbrtu_pkg::REG_FUNC_CODE:    function_code <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      waiting_reply <= 1'b0;
      elapsed_ticks <= '0;
      rx_count      <= '0;
      rx_crc        <= mbrtu_pkg::CRC_INIT;
      header_ok     <= 1'b1;
      data_bytes    <= '0;
      crc_low_byte  <= '0;
      x_value       <= '0;
      y_value       <= '0;
      failures      <= '0;
      link_up       <= 1'b0;
    end else begin
      waiting_reply <= waiting_reply_next;
      elapsed_ticks <= elapsed_ticks_next;
      rx_count      <= rx_count_next;
      rx_crc        <= rx_crc_next;
      header_ok     <= header_ok_next;
      data_bytes    <= data_bytes_next;
      crc_low_byte  <= crc_low_byte_next;
      x_value       <= x_value_next;
      y_value       <= y_value_next;
      failures      <= failures_next;
      link_up       <= link_up_next;
    end
  end

  // The first frame byte goes out with the sending tick; the rest follow
  // from the byte index while the CRC is folded in on the way.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      bursting     <= 1'b0;
      tx_idx       <= '0;
      tx_crc       <= mbrtu_pkg::CRC_INIT;
    end else if (item_fire) begin
      result_valid <= 1'b1;
      if (send) begin
        bursting <= 1'b1;
        tx_idx   <= mbrtu_pkg::FRM_FUNC;
        tx_crc   <= mbrtu_pkg::crc_feed(mbrtu_pkg::CRC_INIT, slave_address);
      end
    end else if (bursting && result_fire) begin
      tx_idx <= tx_idx + 3'd1;
      if (tx_idx < mbrtu_pkg::FRM_CRC_L) begin
        tx_crc <= mbrtu_pkg::crc_feed(tx_crc, tx_byte_sel);
      end
      if (tx_idx == mbrtu_pkg::FRM_CRC_H) begin
        bursting <= 1'b0;
      end
    end else if (result_fire) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_fire) begin
      result.tx_valid      <= send;
      result.tx_byte       <= send ? slave_address : 8'h00;
      result.joy_x         <= x_value_next;
      result.joy_y         <= y_value_next;
      result.link_active   <= link_up_next;
      result.failure_count <= failures_next;
      result.last          <= !send;
    end else if (bursting && result_fire) begin
      result.tx_valid <= 1'b1;
      result.tx_byte  <= tx_byte_sel;
      result.last     <= (tx_idx == mbrtu_pkg::FRM_CRC_H);
    end
  end

  `MBRTU_ASSERT_IMP(a_no_item_in_burst, clk, rst, item_valid && !item_stall, !bursting)
  `MBRTU_ASSERT_IMP(a_burst_is_tx, clk, rst, bursting, result_valid && result.tx_valid)
  `MBRTU_ASSERT_IMP(a_idle_rx_clear, clk, rst, !waiting_reply, rx_count == 4'd0)
  `MBRTU_ASSERT_NXT(a_send_waits, clk, rst, send, waiting_reply && result.tx_valid)

endmodule

/* tb/sv/poller_checker.sv */
// ----------------------------------------------------------------------------
// Modbus RTU register poller: result checker
// Watches the item, result and register ports, predicts every result beat of
// the poller and compares each accepted beat with the oldest prediction.
// ----------------------------------------------------------------------------
module poller_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  input  logic                item_stall,
  input  mbrtu_pkg::item_t    item,
  input  logic                result_valid,
  input  logic                result_stall,
  input  mbrtu_pkg::result_t  result,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  output int unsigned         mismatches,
  output int unsigned         beats_owed,
  output logic                reply_awaited
);

  logic [15:0] poll_period;
  logic [15:0] reply_timeout;
  logic [7:0]  fail_limit;
  logic [7:0]  slave_addr;
  logic [7:0]  func_code;

  logic                             awaiting;
  logic [mbrtu_pkg::TIMER_BITS-1:0] ticks_since_send;
  logic [3:0]                       rx_pos;
  logic [15:0]                      rx_sum;
  logic                             header_good;
  logic [31:0]                      reg_bytes;
  logic [7:0]                       sum_low;
  logic [15:0]                      x_reg;
  logic [15:0]                      y_reg;
  logic [7:0]                       fail_run;
  logic                             link_up;

  mbrtu_pkg::result_t due_beats[$];

  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] acc;
    acc = crc ^ {8'h00, data};
    repeat (8) acc = acc[0] ? ((acc >> 1) ^ mbrtu_pkg::CRC_POLY) : (acc >> 1);
    return acc;
  endfunction

  function automatic mbrtu_pkg::result_t status_beat(input logic txv, input logic [7:0] txb,
                                                     input logic fin);
    mbrtu_pkg::result_t r;
    r.tx_valid      = txv;
    r.tx_byte       = txb;
    r.joy_x         = x_reg;
    r.joy_y         = y_reg;
    r.link_active   = link_up;
    r.failure_count = fail_run;
    r.last          = fin;
    return r;
  endfunction

  function automatic string beat_text(input mbrtu_pkg::result_t r);
    return $sformatf("tx %0b/%02h x %0d y %0d link %0b failures %0d last %0b",
                     r.tx_valid, r.tx_byte, r.joy_x, r.joy_y, r.link_active,
                     r.failure_count, r.last);
  endfunction

  task automatic restart_frame();
    rx_pos      = 4'd0;
    rx_sum      = mbrtu_pkg::CRC_INIT;
    header_good = 1'b1;
    reg_bytes   = 32'h0;
    sum_low     = 8'h00;
  endtask

  task automatic note_failure();
    if (fail_run != 8'hFF) fail_run++;
  endtask

  task automatic power_on();
    poll_period      = 16'd20;
    reply_timeout    = 16'd50;
    fail_limit       = 8'd3;
    slave_addr       = 8'd3;
    func_code        = 8'd3;
    awaiting         = 1'b0;
    ticks_since_send = '0;
    restart_frame();
    x_reg    = 16'h0;
    y_reg    = 16'h0;
    fail_run = 8'h00;
    link_up  = 1'b0;
    due_beats.delete();
  endtask

  task automatic advance_poller(input mbrtu_pkg::item_t it);
    logic [7:0]  frame [8];
    logic [15:0] sum;
    logic        sent;
    int          i;
    sent = 1'b0;
    if (it.cmd == mbrtu_pkg::CMD_TICK) begin
      if (ticks_since_send != '1) ticks_since_send++;
      if (!awaiting) begin
        if (ticks_since_send >= poll_period) begin
          frame[mbrtu_pkg::FRM_ADDR]    = slave_addr;
          frame[mbrtu_pkg::FRM_FUNC]    = func_code;
          frame[mbrtu_pkg::FRM_START_H] = mbrtu_pkg::REQ_ZERO;
          frame[mbrtu_pkg::FRM_START_L] = mbrtu_pkg::REQ_ZERO;
          frame[mbrtu_pkg::FRM_COUNT_H] = mbrtu_pkg::REQ_ZERO;
          frame[mbrtu_pkg::FRM_COUNT_L] = mbrtu_pkg::REQ_COUNT;
          sum = mbrtu_pkg::CRC_INIT;
          for (i = 0; i < 6; i++) sum = crc_step(sum, frame[i]);
          frame[mbrtu_pkg::FRM_CRC_L] = sum[7:0];
          frame[mbrtu_pkg::FRM_CRC_H] = sum[15:8];
          ticks_since_send = '0;
          awaiting = 1'b1;
          restart_frame();
          for (i = 0; i < 8; i++) due_beats.push_back(status_beat(1'b1, frame[i], i == 7));
          sent = 1'b1;
        end
      end else if (ticks_since_send >= reply_timeout) begin
        note_failure();
        if (fail_run >= fail_limit) begin
          x_reg   = 16'h0;
          y_reg   = 16'h0;
          link_up = 1'b0;
        end
        awaiting = 1'b0;
        restart_frame();
      end
    end else if (awaiting) begin
      if (rx_pos < mbrtu_pkg::RX_CRC_LO_POS) begin
        rx_sum = crc_step(rx_sum, it.rx_byte);
        if (rx_pos == 4'd0 && it.rx_byte != slave_addr) header_good = 1'b0;
        if (rx_pos == 4'd1 && it.rx_byte != func_code) header_good = 1'b0;
        if (rx_pos >= 4'd3) reg_bytes = {reg_bytes[23:0], it.rx_byte};
        rx_pos++;
      end else if (rx_pos == mbrtu_pkg::RX_CRC_LO_POS) begin
        sum_low = it.rx_byte;
        rx_pos++;
      end else begin
        if ({it.rx_byte, sum_low} == rx_sum && header_good) begin
          fail_run = 8'h00;
          link_up  = 1'b1;
          x_reg    = reg_bytes[31:16];
          y_reg    = reg_bytes[15:0];
        end else begin
          note_failure();
        end
        awaiting = 1'b0;
        restart_frame();
      end
    end
    if (!sent) due_beats.push_back(status_beat(1'b0, 8'h00, 1'b1));
  endtask

  always @(posedge clk) begin : watch_beats
    mbrtu_pkg::result_t want;
    if (rst) begin
      power_on();
    end else begin
      if (result_valid && !result_stall) begin
        if (due_beats.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result beat: expected none, actual %s", $time,
                   beat_text(result));
        end else begin
          want = due_beats.pop_front();
          if (want.tx_valid !== result.tx_valid || want.tx_byte !== result.tx_byte ||
              want.joy_x !== result.joy_x || want.joy_y !== result.joy_y ||
              want.link_active !== result.link_active ||
              want.failure_count !== result.failure_count || want.last !== result.last) begin
            mismatches++;
            $display("%0t: result mismatch: expected %s, actual %s", $time,
                     beat_text(want), beat_text(result));
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          mbrtu_pkg::REG_POLL_PERIOD:  poll_period = cfg_data;
          mbrtu_pkg::REG_TIMEOUT:      reply_timeout = cfg_data;
          mbrtu_pkg::REG_MAX_FAILURES: fail_limit = cfg_data[7:0];
          mbrtu_pkg::REG_SLAVE_ADDR:   slave_addr = cfg_data[7:0];
          mbrtu_pkg::REG_FUNC_CODE:    func_code = cfg_data[7:0];
          default: ;
        endcase
      end
      if (item_valid && !item_stall) advance_poller(item);
    end
    beats_owed    = due_beats.size();
    reply_awaited = awaiting;
  end

endmodule

/* tb/sv/testbench.sv */
// ----------------------------------------------------------------------------
// Modbus RTU register poller: testbench
// Drives ticks, reply frames and register writes into the poller, with random
// idling on both channels, and leaves the checking to the result checker.
// ----------------------------------------------------------------------------
module testbench;

  typedef enum {FLAW_NONE, FLAW_ADDR, FLAW_FUNC, FLAW_CRC, FLAW_SHORT, FLAW_TICKS} flaw_t;

  logic               clk;
  logic               rst;
  logic               item_valid;
  logic               item_stall;
  mbrtu_pkg::item_t   item;
  logic               result_valid;
  logic               result_stall;
  mbrtu_pkg::result_t result;
  logic               cfg_we;
  logic [2:0]         cfg_index;
  logic [15:0]        cfg_data;

  int unsigned mismatches;
  int unsigned beats_owed;
  logic        reply_awaited;

  int          idle_pct;
  int          stall_pct;
  int          items_sent;
  logic [7:0]  cur_addr;
  logic [7:0]  cur_fc;

  modbus_rtu_register_poller_core DUT (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  poller_checker watch (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item_stall    (item_stall),
    .item          (item),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .result        (result),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .mismatches    (mismatches),
    .beats_owed    (beats_owed),
    .reply_awaited (reply_awaited)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(negedge clk) begin
    result_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  function automatic logic [15:0] reply_crc(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] acc;
    acc = crc ^ {8'h00, data};
    repeat (8) acc = acc[0] ? ((acc >> 1) ^ mbrtu_pkg::CRC_POLY) : (acc >> 1);
    return acc;
  endfunction

  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic drive_item(input logic c, input logic [7:0] b);
    while ($urandom_range(0, 99) < idle_pct) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid <= 1'b1;
    item <= '{cmd: c, rx_byte: b};
    @(posedge clk);
    while (item_stall) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic tick();
    drive_item(mbrtu_pkg::CMD_TICK, 8'($urandom_range(0, 255)));
  endtask

  task automatic poll();
    while (!reply_awaited) tick();
  endtask

  task automatic settle();
    item_valid <= 1'b0;
    do @(negedge clk); while (beats_owed != 0);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
  endtask

  task automatic set_config(input logic [15:0] period, input logic [15:0] tmo,
                            input logic [7:0] maxf, input logic [7:0] addr,
                            input logic [7:0] fc);
    settle();
    write_reg(mbrtu_pkg::REG_POLL_PERIOD, period);
    write_reg(mbrtu_pkg::REG_TIMEOUT, tmo);
    write_reg(mbrtu_pkg::REG_MAX_FAILURES, {8'h00, maxf});
    write_reg(mbrtu_pkg::REG_SLAVE_ADDR, {8'h00, addr});
    write_reg(mbrtu_pkg::REG_FUNC_CODE, {8'h00, fc});
    write_reg(mbrtu_pkg::REG_FUNC_CODE + 3'd1 + 3'($urandom_range(0, 2)),
              16'($urandom_range(0, 65535)));
    cfg_we   <= 1'b0;
    cur_addr = addr;
    cur_fc   = fc;
  endtask

  task automatic send_reply(input logic [15:0] x, input logic [15:0] y, input flaw_t flaw);
    logic [7:0]  frame [9];
    logic [15:0] sum;
    int          cut;
    int          gap_at;
    int          i;
    frame[0] = cur_addr;
    frame[1] = cur_fc;
    frame[2] = ($urandom_range(0, 1) != 0) ? 8'h04 : 8'($urandom_range(0, 255));
    frame[3] = x[15:8];
    frame[4] = x[7:0];
    frame[5] = y[15:8];
    frame[6] = y[7:0];
    if (flaw == FLAW_ADDR) frame[0] = cur_addr ^ (8'h01 << $urandom_range(0, 7));
    if (flaw == FLAW_FUNC) frame[1] = cur_fc ^ (8'h01 << $urandom_range(0, 7));
    sum = mbrtu_pkg::CRC_INIT;
    for (i = 0; i < 7; i++) sum = reply_crc(sum, frame[i]);
    frame[7] = sum[7:0];
    frame[8] = sum[15:8];
    if (flaw == FLAW_CRC) frame[7 + $urandom_range(0, 1)] ^= 8'h01 << $urandom_range(0, 7);
    cut    = (flaw == FLAW_SHORT) ? $urandom_range(1, 8) : 9;
    gap_at = (flaw == FLAW_TICKS) ? $urandom_range(1, 8) : -1;
    for (i = 0; i < cut; i++) begin
      if (i == gap_at) tick();
      drive_item(mbrtu_pkg::CMD_BYTE, frame[i]);
    end
    if (flaw == FLAW_SHORT) begin
      while (reply_awaited) tick();
    end
  endtask

  task automatic random_exchange();
    flaw_t flaw;
    if ($urandom_range(0, 4) == 0) begin
      drive_item(($urandom_range(0, 1) != 0) ? mbrtu_pkg::CMD_BYTE : mbrtu_pkg::CMD_TICK,
                 8'($urandom_range(0, 255)));
    end
    poll();
    case ($urandom_range(0, 9))
      5: flaw = FLAW_ADDR;
      6: flaw = FLAW_FUNC;
      7: flaw = FLAW_CRC;
      8: flaw = FLAW_SHORT;
      9: flaw = FLAW_TICKS;
      default: flaw = FLAW_NONE;
    endcase
    send_reply(pick_word(), pick_word(), flaw);
  endtask

  task automatic run_until(input int target);
    int n;
    n = 0;
    while (items_sent < target) begin
      if (n % 6 == 0) begin
        set_config(16'($urandom_range(0, 4)), 16'($urandom_range(0, 12)),
                   8'($urandom_range(0, 4)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)));
      end
      random_exchange();
      n++;
    end
  endtask

  initial begin
    rst          = 1'b1;
    item_valid   = 1'b0;
    item         = '0;
    result_stall = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    idle_pct     = 12;
    stall_pct    = 73;
    items_sent   = 0;
    cur_addr     = 8'd3;
    cur_fc       = 8'd3;
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    set_config(16'd2, 16'd3, 8'd2, 8'h00, 8'hFF);
    drive_item(mbrtu_pkg::CMD_BYTE, 8'hA5);
    poll();
    send_reply(16'h8000, 16'h7FFF, FLAW_NONE);
    poll();
    send_reply(16'h1234, 16'hFFFF, FLAW_CRC);
    poll();
    repeat (3) tick();
    set_config(16'd0, 16'd0, 8'd0, 8'hFF, 8'h00);
    tick();
    tick();
    drive_item(mbrtu_pkg::CMD_BYTE, 8'hFF);
    tick();
    send_reply(16'h0000, 16'h8001, FLAW_NONE);

    run_until(items_sent + 80);
    idle_pct  = 73;
    stall_pct = 12;
    run_until(items_sent + 80);
    idle_pct  = 0;
    stall_pct = 0;
    run_until(items_sent + 80);

    // A good reply, then the failsafe on the first timeout.
    set_config(16'd1, 16'd2, 8'd1, 8'hFF, 8'h00);
    poll();
    send_reply(16'h7FFF, 16'h8000, FLAW_NONE);
    poll();
    while (reply_awaited) tick();

    settle();
    repeat (20) @(negedge clk);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl
rtl/mbrtu_pkg.sv
rtl/modbus_rtu_register_poller_core.sv
tb/sv/poller_checker.sv
tb/sv/testbench.sv
